// File: hw/rtl/lodc_pkg.sv
// Package for the lock order deadlock checker.
// Holds the status codes, controller states and the command and status structs.
// It depends on nothing else.
package lodc_pkg;

    // Result codes reported with every item.
    typedef enum logic [2:0] {
        ST_OK             = 3'd0,
        ST_DEADLOCK       = 3'd1,
        ST_MULTI_UNLOCK   = 3'd2,
        ST_INVALID_UNLOCK = 3'd3,
        ST_TABLE_FULL     = 3'd4,
        ST_STACK_FULL     = 3'd5
    } status_t;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_DECIDE,
        S_EDGE_CHK,
        S_REACH_PICK,
        S_REACH_MERGE,
        S_FINISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic scan_rd;
        logic scan_cmp;
        logic decide;
        logic edge_chk;
        logic reach_pick;
        logic reach_merge;
    } cmd_t;

    // Status flags from the datapath to the controller.
    typedef struct packed {
        logic scan_end;
        logic key_hit;
        logic need_edge;
        logic edge_known;
        logic reach_hit;
        logic pend_empty;
    } flags_t;

endpackage

// File: hw/rtl/lodc_ctrl.sv
// Controller state machine of the lock order deadlock checker.
// Sequences key lookup, decision, edge check and reachability walk.
// Depends on lodc_pkg.
module lodc_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  lodc_pkg::flags_t flags,
    output lodc_pkg::cmd_t  cmd,
    output logic            busy,
    output logic            done
);
    import lodc_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                state_next = flags.scan_end ? S_DECIDE : S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                state_next = flags.key_hit ? S_DECIDE : S_SCAN_RD;
            end
            S_DECIDE:
            begin
                state_next = flags.need_edge ? S_EDGE_CHK : S_FINISH;
            end
            S_EDGE_CHK:
            begin
                state_next = flags.edge_known ? S_FINISH : S_REACH_PICK;
            end
            S_REACH_PICK:
            begin
                if (flags.reach_hit || flags.pend_empty)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_REACH_MERGE;
                end
            end
            S_REACH_MERGE:
            begin
                state_next = S_REACH_PICK;
            end
            S_FINISH:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        cmd             = '0;
        cmd.load        = (state_reg == S_IDLE) && start;
        cmd.scan_rd     = (state_reg == S_SCAN_RD);
        cmd.scan_cmp    = (state_reg == S_SCAN_CMP);
        cmd.decide      = (state_reg == S_DECIDE);
        cmd.edge_chk    = (state_reg == S_EDGE_CHK);
        cmd.reach_pick  = (state_reg == S_REACH_PICK);
        cmd.reach_merge = (state_reg == S_REACH_MERGE);
        busy            = (state_reg != S_IDLE);
        done            = (state_reg == S_FINISH);
    end

endmodule

// File: hw/rtl/lodc_datapath.sv
// Datapath of the lock order deadlock checker.
// Holds the key table, held stack and order matrix memories and the walk registers.
// Depends on lodc_pkg.
module lodc_datapath
#(
    parameter int MAX_LOCKS   = 32,
    parameter int STACK_DEPTH = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  lodc_pkg::cmd_t   cmd,
    input  logic             req_type,
    input  logic [31:0]      lock_key,
    output lodc_pkg::flags_t flags,
    output logic [2:0]       status,
    output logic [4:0]       lock_index
);
    import lodc_pkg::*;

    localparam int IW  = (MAX_LOCKS > 1) ? $clog2(MAX_LOCKS) : 1;
    localparam int CW  = $clog2(MAX_LOCKS + 1);
    localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DW  = $clog2(STACK_DEPTH + 1);

    // Memories.
    logic [31:0]          key_mem   [MAX_LOCKS];
    logic [IW-1:0]        stack_mem [STACK_DEPTH];
    logic [MAX_LOCKS-1:0] mat_mem   [MAX_LOCKS];

    // Control registers.
    logic [CW-1:0]        count_reg,  count_next;
    logic [DW-1:0]        depth_reg,  depth_next;
    logic [MAX_LOCKS-1:0] vld_reg,    vld_next;

    // Item registers.
    logic                 op_reg;
    logic [31:0]          key_reg;
    logic [CW-1:0]        scan_reg;
    logic                 found_reg;
    logic [IW-1:0]        id_reg;
    logic [MAX_LOCKS-1:0] seen_reg;
    logic [MAX_LOCKS-1:0] done_reg;
    logic [MAX_LOCKS-1:0] top_row_reg;
    status_t              status_reg;

    // Registered read data.
    logic [31:0]          key_rd_reg;
    logic [IW-1:0]        stack_rd_reg;
    logic [MAX_LOCKS-1:0] row_rd_reg;
    logic                 row_rv_reg;

    // Combinational helpers.
    logic [MAX_LOCKS-1:0] row_eff;
    logic [MAX_LOCKS-1:0] id_bit;
    logic [MAX_LOCKS-1:0] pend;
    logic [IW-1:0]        pick;
    logic [IW-1:0]        row_addr;
    logic [DW-1:0]        depth_m1;
    logic [IW-1:0]        new_id;
    logic                 table_full;
    logic                 stack_full;
    logic                 push_ok;

    // Lowest pending row of the walk.
    function automatic logic [IW-1:0] lowest(input logic [MAX_LOCKS-1:0] v);
        logic [IW-1:0] r;
        r = '0;
        for (int i = MAX_LOCKS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = IW'(i);
            end
        end
        return r;
    endfunction

    assign row_eff    = row_rv_reg ? row_rd_reg : '0;
    assign id_bit     = {{(MAX_LOCKS-1){1'b0}}, 1'b1} << id_reg;
    assign pend       = seen_reg & ~done_reg;
    assign pick       = lowest(pend);
    assign depth_m1   = depth_reg - 1'b1;
    assign new_id     = found_reg ? id_reg : count_reg[IW-1:0];
    assign table_full = !found_reg && (count_reg == CW'(MAX_LOCKS));
    assign stack_full = (depth_reg == DW'(STACK_DEPTH));
    assign push_ok    = !op_reg && !table_full && !stack_full;
    assign row_addr   = cmd.reach_pick ? pick : stack_rd_reg;

    // Flags for the controller.
    always_comb
    begin
        flags            = '0;
        flags.scan_end   = (scan_reg >= count_reg);
        flags.key_hit    = (key_rd_reg == key_reg);
        flags.need_edge  = push_ok && (depth_reg != '0) && (stack_rd_reg != new_id);
        flags.edge_known = |(row_eff & id_bit);
        flags.reach_hit  = seen_reg[stack_rd_reg];
        flags.pend_empty = (pend == '0);
    end

    // Memory reads, registered.
    always_ff @(posedge clk)
    begin
        key_rd_reg <= key_mem[scan_reg[IW-1:0]];
        row_rd_reg <= mat_mem[row_addr];
        row_rv_reg <= vld_reg[row_addr];
        if (cmd.load)
        begin
            stack_rd_reg <= stack_mem[depth_m1[SAW-1:0]];
        end
    end

    // Memory writes.
    always_ff @(posedge clk)
    begin
        if (cmd.decide && push_ok && !found_reg)
        begin
            key_mem[count_reg[IW-1:0]] <= key_reg;
        end
        if (cmd.reach_pick && !seen_reg[stack_rd_reg] && (pend == '0))
        begin
            mat_mem[stack_rd_reg] <= top_row_reg | id_bit;
        end
        if ((cmd.decide && push_ok && !flags.need_edge)
            || (cmd.edge_chk && flags.edge_known)
            || (cmd.reach_pick && !seen_reg[stack_rd_reg] && (pend == '0)))
        begin
            stack_mem[depth_reg[SAW-1:0]] <= cmd.decide ? new_id : id_reg;
        end
    end

    // Next values of the persistent control state.
    always_comb
    begin
        count_next = count_reg;
        depth_next = depth_reg;
        vld_next   = vld_reg;
        if (cmd.decide)
        begin
            if (push_ok && !found_reg)
            begin
                count_next = count_reg + 1'b1;
            end
            if (push_ok && !flags.need_edge)
            begin
                depth_next = depth_reg + 1'b1;
            end
            if (op_reg && (depth_reg != '0) && found_reg && (stack_rd_reg == id_reg))
            begin
                depth_next = depth_m1;
            end
        end
        if (cmd.edge_chk && flags.edge_known)
        begin
            depth_next = depth_reg + 1'b1;
        end
        if (cmd.reach_pick && !seen_reg[stack_rd_reg] && (pend == '0))
        begin
            depth_next = depth_reg + 1'b1;
            vld_next[stack_rd_reg] = 1'b1;
        end
    end

    // Persistent control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            depth_reg <= '0;
            vld_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            depth_reg <= depth_next;
            vld_reg   <= vld_next;
        end
    end

    // Per-item registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= req_type;
            key_reg    <= lock_key;
            scan_reg   <= '0;
            found_reg  <= 1'b0;
            id_reg     <= '0;
            status_reg <= ST_OK;
        end
        if (cmd.scan_cmp)
        begin
            if (key_rd_reg == key_reg)
            begin
                found_reg <= 1'b1;
                id_reg    <= scan_reg[IW-1:0];
            end
            else
            begin
                scan_reg <= scan_reg + 1'b1;
            end
        end
        if (cmd.decide)
        begin
            if (op_reg)
            begin
                if (!found_reg)
                begin
                    id_reg <= '0;
                end
                priority if (depth_reg == '0)
                begin
                    status_reg <= ST_MULTI_UNLOCK;
                end
                else if (!found_reg || (stack_rd_reg != id_reg))
                begin
                    status_reg <= ST_INVALID_UNLOCK;
                end
                else
                begin
                    status_reg <= ST_OK;
                end
            end
            else
            begin
                priority if (table_full)
                begin
                    status_reg <= ST_TABLE_FULL;
                    id_reg     <= '0;
                end
                else if (stack_full)
                begin
                    status_reg <= ST_STACK_FULL;
                    if (!found_reg)
                    begin
                        id_reg <= '0;
                    end
                end
                else
                begin
                    id_reg <= new_id;
                end
            end
        end
        if (cmd.edge_chk)
        begin
            top_row_reg <= row_eff;
            seen_reg    <= id_bit;
            done_reg    <= '0;
        end
        if (cmd.reach_pick)
        begin
            if (seen_reg[stack_rd_reg])
            begin
                status_reg <= ST_DEADLOCK;
            end
            else if (pend != '0)
            begin
                done_reg[pick] <= 1'b1;
            end
        end
        if (cmd.reach_merge)
        begin
            seen_reg <= seen_reg | row_eff;
        end
    end

    assign status     = status_reg;
    assign lock_index = 5'(id_reg);

endmodule

// File: hw/rtl/lock_order_deadlock_checker.sv
// Top level of the lock order deadlock checker.
// Joins the controller (lodc_ctrl) and the datapath (lodc_datapath); uses lodc_pkg.
//
//   Channel  Ports                       Handshake
//   input    req_type, lock_key          taken when start is high and busy is low
//   result   status, lock_index          valid for one cycle while strobe is high
//
// Each item is accepted, then scans the key table entry by entry (a read and a compare
// per entry, ending early when the key is found) and is decided; a push that would add
// an edge to a non-empty stack then gets an edge check, and when that edge is new a
// reachability walk visits matrix rows (a pick and a merge per row) before it closes.
// The key scan and the walk both go through memories with registered reads.
// Reset clears the key count, stack depth and matrix row valid bits at once.
// The receiver cannot stall: each result is shown once and then dropped.
module lock_order_deadlock_checker
#(
    parameter int MAX_LOCKS   = 32,
    parameter int STACK_DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        req_type,
    input  logic [31:0] lock_key,
    output logic        strobe,
    output logic [2:0]  status,
    output logic [4:0]  lock_index
);
    import lodc_pkg::*;

    cmd_t   cmd;
    flags_t flags;

    // Sequencer.
    lodc_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .flags (flags),
        .cmd   (cmd),
        .busy  (busy),
        .done  (strobe)
    );

    // Storage and walk logic.
    lodc_datapath
    #(
        .MAX_LOCKS   (MAX_LOCKS),
        .STACK_DEPTH (STACK_DEPTH)
    )
    u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .req_type   (req_type),
        .lock_key   (lock_key),
        .flags      (flags),
        .status     (status),
        .lock_index (lock_index)
    );

endmodule

// File: sim/lock_order_deadlock_checker_tb.sv
// Testbench for lock_order_deadlock_checker: lock and unlock items, checked against a predictor.
// Depends on lodc_pkg for the status codes and on the block's RTL.
module lock_order_deadlock_checker_tb;
    import lodc_pkg::*;

    localparam int  NUM_LOCKS   = 32;
    localparam int  HELD_MAX    = 16;
    localparam bit  REQ_LOCK    = 1'b0;
    localparam bit  REQ_UNLOCK  = 1'b1;
    localparam int  CYCLE_LIMIT = 600000;
    localparam int  POOL_SIZE   = 36;

    typedef struct {
        bit        op;
        bit [31:0] key;
    } lock_req_t;

    typedef struct {
        status_t   st;
        bit [4:0]  idx;
    } lock_resp_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        req_type = 1'b0;
    logic [31:0] lock_key = 32'd0;
    logic        busy;
    logic        strobe;
    logic [2:0]  status;
    logic [4:0]  lock_index;

    lock_req_t   pending_reqs[$];
    lock_resp_t  expected_resps[$];
    bit [31:0]   key_pool[POOL_SIZE];

    // Predictor state: key table, ordering matrix and held-lock stack.
    bit [31:0]   known_keys[NUM_LOCKS];
    int          known_total;
    bit [31:0]   order_rows[NUM_LOCKS];
    int          held_ids[HELD_MAX];
    int          held_count;

    int          cycles;
    int          sent_count;
    int          mismatches;
    int          status_seen[6];
    bit          drain_hold;

    lock_order_deadlock_checker u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req_type   (req_type),
        .lock_key   (lock_key),
        .strobe     (strobe),
        .status     (status),
        .lock_index (lock_index)
    );

    // Clock.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Set of ids reachable from src over the ordering graph.
    function automatic bit [31:0] reachable_from(input int src);
        bit [31:0] seen;
        bit [31:0] grown;
        seen = 32'd1 << src;
        for (int round = 0; round < NUM_LOCKS; round++)
        begin
            grown = seen;
            for (int i = 0; i < NUM_LOCKS; i++)
                if (seen[i])
                    grown |= order_rows[i];
            if (grown == seen)
                break;
            seen = grown;
        end
        return seen;
    endfunction

    // Works out the result of one lock event and updates the predictor state.
    function automatic lock_resp_t predict_lock_event(input lock_req_t req);
        lock_resp_t resp;
        int         id;
        bit         known;
        bit         do_push;
        int         top;
        bit [31:0]  reach;
        id = 0;
        known = 1'b0;
        do_push = 1'b1;
        resp.st = ST_OK;
        for (int i = 0; i < known_total; i++)
        begin
            if (!known && known_keys[i] == req.key)
            begin
                known = 1'b1;
                id = i;
            end
        end
        if (req.op == REQ_LOCK)
        begin
            if (!known && known_total >= NUM_LOCKS)
            begin
                resp.st = ST_TABLE_FULL;
                id = 0;
            end
            else if (held_count >= HELD_MAX)
            begin
                resp.st = ST_STACK_FULL;
            end
            else
            begin
                if (!known)
                begin
                    id = known_total;
                    known_keys[id] = req.key;
                    known_total++;
                end
                if (held_count > 0)
                begin
                    top = held_ids[held_count - 1];
                    if (top != id && !order_rows[top][id])
                    begin
                        reach = reachable_from(id);
                        if (reach[top])
                        begin
                            resp.st = ST_DEADLOCK;
                            do_push = 1'b0;
                        end
                        else
                            order_rows[top][id] = 1'b1;
                    end
                end
                if (do_push)
                begin
                    held_ids[held_count] = id;
                    held_count++;
                end
            end
        end
        else
        begin
            if (held_count == 0)
                resp.st = ST_MULTI_UNLOCK;
            else if (!known || held_ids[held_count - 1] != id)
                resp.st = ST_INVALID_UNLOCK;
            else
                held_count--;
        end
        resp.idx = id[4:0];
        return resp;
    endfunction

    // Queues one item for the driver.
    task automatic queue_item(input bit op, input bit [31:0] key);
        lock_req_t req;
        req.op = op;
        req.key = key;
        pending_reqs.push_back(req);
    endtask

    // Cycle limit.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycles, expected_resps.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // Driver: presents queued items, with random gaps and drain pauses.
    always @(posedge clk)
    begin
        bit        present;
        bit        quiet;
        lock_req_t req;
        if (rst_n)
        begin
            present = start;
            if (start && !busy)
            begin
                req.op = req_type;
                req.key = lock_key;
                expected_resps.push_back(predict_lock_event(req));
                sent_count++;
                present = 1'b0;
                if (sent_count == 120 || sent_count == 330)
                    drain_hold = 1'b1;
            end
            if (drain_hold && expected_resps.size() == 0 && !present)
                drain_hold = 1'b0;
            if (!present && !drain_hold && pending_reqs.size() > 0)
            begin
                // Between items 180 and 280 the sender never idles.
                quiet = (sent_count >= 180 && sent_count < 280);
                if (quiet || $urandom_range(99) >= 17)
                begin
                    req = pending_reqs.pop_front();
                    req_type <= req.op;
                    lock_key <= req.key;
                    present = 1'b1;
                end
            end
            start <= present;
        end
    end

    // Monitor: each strobed result is checked against the oldest expectation.
    always @(posedge clk)
    begin
        lock_resp_t want;
        if (rst_n && strobe)
        begin
            if (expected_resps.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: status %0d index %0d", status, lock_index);
            end
            else
            begin
                want = expected_resps.pop_front();
                if (status <= 3'd5)
                    status_seen[status]++;
                if (status !== want.st || lock_index !== want.idx)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: status exp %0d got %0d, index exp %0d got %0d",
                                 want.st, status, want.idx, lock_index);
                end
            end
        end
    end

    // Stimulus and end of run.
    initial
    begin
        int depth;
        int pick;
        int burst[$];
        cycles = 0;
        sent_count = 0;
        mismatches = 0;
        known_total = 0;
        held_count = 0;
        drain_hold = 1'b0;
        foreach (order_rows[i])
            order_rows[i] = 32'd0;
        foreach (status_seen[i])
            status_seen[i] = 0;

        // Directed part: empty pops, ordering, deadlock, re-acquire, bad pops.
        queue_item(REQ_UNLOCK, 32'hFFFF_FFFF);
        queue_item(REQ_LOCK, 32'h0000_0000);
        queue_item(REQ_LOCK, 32'hFFFF_FFFF);
        queue_item(REQ_UNLOCK, 32'h0000_0000);
        queue_item(REQ_UNLOCK, 32'h1234_5678);
        queue_item(REQ_UNLOCK, 32'hFFFF_FFFF);
        queue_item(REQ_UNLOCK, 32'h0000_0000);
        queue_item(REQ_UNLOCK, 32'h0000_0000);
        queue_item(REQ_LOCK, 32'hFFFF_FFFF);
        queue_item(REQ_LOCK, 32'h0000_0000);
        queue_item(REQ_LOCK, 32'hFFFF_FFFF);
        queue_item(REQ_LOCK, 32'hFFFF_FFFF);
        queue_item(REQ_UNLOCK, 32'hFFFF_FFFF);
        queue_item(REQ_UNLOCK, 32'hFFFF_FFFF);
        // Re-acquiring the top lock until the stack is full, then unwinding.
        for (int i = 0; i < 17; i++)
            queue_item(REQ_LOCK, 32'hA5A5_5A5A);
        for (int i = 0; i < 16; i++)
            queue_item(REQ_UNLOCK, 32'hA5A5_5A5A);

        // Random part: mostly nested lock and unlock sequences over a pool of keys
        // slightly larger than the table, so the table fills up along the way.
        foreach (key_pool[i])
            key_pool[i] = $urandom;
        while (pending_reqs.size() < 440)
        begin
            if ($urandom_range(9) < 8)
            begin
                depth = ($urandom_range(19) == 0) ? 17 : $urandom_range(1, 5);
                burst.delete();
                for (int i = 0; i < depth; i++)
                begin
                    pick = $urandom_range(POOL_SIZE - 1);
                    burst.push_back(pick);
                    queue_item(REQ_LOCK, key_pool[pick]);
                end
                while (burst.size() > 0)
                    queue_item(REQ_UNLOCK, key_pool[burst.pop_back()]);
            end
            else if ($urandom_range(1))
                queue_item(1'($urandom_range(1)), key_pool[$urandom_range(POOL_SIZE - 1)]);
            else
                queue_item(1'($urandom_range(1)), $urandom);
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_reqs.size() == 0 && !start && !drain_hold && expected_resps.size() == 0);
        repeat (200) @(posedge clk);

        $display("Checked %0d lock and unlock items: ok %0d, deadlock %0d, double unlock %0d,",
                 sent_count, status_seen[0], status_seen[1], status_seen[2]);
        $display("bad unlock %0d, table full %0d, stack full %0d; %0d locks registered",
                 status_seen[3], status_seen[4], status_seen[5], known_total);
        if (mismatches == 0 && expected_resps.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
